[design/sirp_pkg.sv]
`default_nettype none

package sirp_pkg;

  localparam int unsigned MAX_RADIX   = 16;
  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned ALPHA_SIZE  = 16;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned STACK_AW    = $clog2(MAX_DIGITS);
  localparam int unsigned COUNT_W     = STACK_AW + 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  // divider retires this many quotient bits per cycle
  localparam int unsigned DIV_BITS    = 8;
  localparam int unsigned DIV_STEPS   = VALUE_W / DIV_BITS;
  localparam int unsigned DIV_STEP_W  = $clog2(DIV_STEPS);

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;

  localparam logic [RADIX_W-1:0]    RADIX_RESET    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] CHARS_LO_RESET = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] CHARS_HI_RESET = 64'h4645444342413938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_CHARS_LO = 2'd1,
    REG_CHARS_HI = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [CFG_DATA_W-1:0] chars_lo;
    logic [CFG_DATA_W-1:0] chars_hi;
  } cfg_t;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  function automatic logic [CHAR_W-1:0] alpha_char(cfg_t cfg, logic [DIGIT_W-1:0] idx);
    logic [CFG_DATA_W-1:0] word;
    word = idx[3] ? cfg.chars_hi : cfg.chars_lo;
    return word[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

[design/signed_int_radix_printer_unit.sv]
// channel  | dir | handshake                     | payload
// ---------+-----+-------------------------------+-------------------------------
// input    | in  | in_valid / in_stall (out)     | value[31:0] signed
// output   | out | out_valid / out_stall (in)    | char_code[7:0], last_char
// config   | in  | cfg_valid / cfg_ready (out)   | cfg_index[1:0], cfg_data[63:0]
//
// Per number: a dequeue, a '-' if negative, then one full division per digit in
// the divider (8 quotient bits a cycle); each digit is then read back from the
// registered digit stack (S_RD) and emitted (S_EMIT), up to 32 digits.
// Reset is synchronous, active high; the digit stack needs no clearing.
// A two-beat queue decouples input from the back end; in_stall rises only when
// it is full. out_stall freezes the output register while out_valid is high; the
// back end waits on it only in S_SIGN and S_EMIT. Config writes are always taken (cfg_ready stays high).
`default_nettype none

module signed_int_radix_printer_unit import sirp_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [VALUE_W-1:0]    value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [CHAR_W-1:0]     char_code,
  output logic                              last_char,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix    <= RADIX_RESET;
      cfg.chars_lo <= CHARS_LO_RESET;
      cfg.chars_hi <= CHARS_HI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIX:    cfg.radix    <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LO: cfg.chars_lo <= cfg_data;
        REG_CHARS_HI: cfg.chars_hi <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sirp_front u_front (
    .cfg       (cfg),
    .in_valid  (in_valid),
    .value     (value),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  sirp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  sirp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (q_empty),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

`default_nettype wire

[design/sirp_ram.sv]
`default_nettype none

module sirp_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/sirp_front.sv]
`default_nettype none

module sirp_front import sirp_pkg::*; (
  input  wire cfg_t                       cfg,
  input  wire logic                       in_valid,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            in_stall,
  input  wire logic                       q_full,
  output logic                            push,
  output item_t                           push_item
);

  logic alpha_ok;

  // radix in 2..MAX_RADIX, every active character printable, not a sign, and unique
  always_comb begin
    logic [CHAR_W-1:0] c;
    alpha_ok = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(MAX_RADIX));
    c = '0;
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (RADIX_W'(i) < cfg.radix) begin
        c = alpha_char(cfg, DIGIT_W'(i));
        if (c == CHAR_PLUS || c == CHAR_MINUS || c < CHAR_LOW || c > CHAR_HIGH) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < ALPHA_SIZE; j++) begin
          if (RADIX_W'(j) < cfg.radix && alpha_char(cfg, DIGIT_W'(j)) == c) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_stall = q_full;

  // bad alphabet: beat is taken and dropped
  assign push          = in_valid && !q_full && alpha_ok;
  assign push_item.neg = value[VALUE_W-1];
  assign push_item.mag = value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value))
                                          : $unsigned(value);

endmodule

`default_nettype wire

[design/sirp_queue.sv]
`default_nettype none

module sirp_queue import sirp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       empty
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[design/sirp_back.sv]
`default_nettype none

module sirp_back import sirp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              empty,
  output logic                   pop,
  input  wire item_t             pop_item,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      char_code,
  output logic                   last_char
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_DIV,
    S_RD,
    S_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_W-1:0]     quo;
  logic [DIGIT_W-1:0]     rem;
  logic [DIV_STEP_W-1:0]  step;
  logic [COUNT_W-1:0]     cnt;

  logic [VALUE_W-1:0]     quo_next;
  logic [DIGIT_W-1:0]     rem_next;
  logic                   step_last;
  logic                   out_free;
  logic                   out_load;
  logic [COUNT_W-1:0]     cnt_dec;
  logic [COUNT_W-1:0]     cnt_inc;
  logic                   stack_we;
  logic [DIGIT_W-1:0]     stack_rdata;

  // restoring long division, DIV_BITS quotient bits per cycle;
  // partial remainder stays below radix so it fits in a digit
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] r;
    q = quo;
    r = rem;
    t = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {r, q[VALUE_W-1]};
      q = {q[VALUE_W-2:0], 1'b0};
      if (t >= cfg.radix) begin
        t    = t - cfg.radix;
        q[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    quo_next = q;
    rem_next = r;
  end

  assign step_last = (step == DIV_STEP_W'(DIV_STEPS - 1));
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state == S_SIGN || state == S_EMIT);
  assign cnt_dec   = cnt - COUNT_W'(1);
  assign cnt_inc   = cnt + COUNT_W'(1);
  assign pop       = (state == S_IDLE) && !empty;
  assign stack_we  = (state == S_DIV) && step_last;

  sirp_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (cnt[STACK_AW-1:0]),
    .wdata (rem_next),
    .raddr (cnt_dec[STACK_AW-1:0]),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      quo       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            quo   <= pop_item.mag;
            rem   <= '0;
            step  <= '0;
            cnt   <= '0;
            state <= pop_item.neg ? S_SIGN : S_DIV;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            char_code <= CHAR_MINUS;
            last_char <= 1'b0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          quo  <= quo_next;
          // digit goes to the stack on the last step; zero input still yields one digit
          rem  <= step_last ? '0 : rem_next;
          step <= step + DIV_STEP_W'(1);
          if (step_last) begin
            cnt <= cnt_inc;
            if (quo_next == '0 || cnt_inc == COUNT_W'(MAX_DIGITS)) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            char_code <= alpha_char(cfg, stack_rdata);
            last_char <= (cnt == COUNT_W'(1));
            cnt       <= cnt_dec;
            state     <= (cnt == COUNT_W'(1)) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= COUNT_W'(MAX_DIGITS))
    else $error("digit count beyond stack depth");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < cfg.radix))
    else $error("partial remainder not below radix");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_EMIT) |-> (cnt != '0))
    else $error("emitting with an empty digit stack");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && cnt == COUNT_W'(1))
      |=> (state == S_IDLE && out_valid && last_char))
    else $error("final digit did not close the item");

endmodule

`default_nettype wire

[verif/tb_signed_int_radix_printer_unit.sv]
module tb_signed_int_radix_printer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sirp_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  // margin after the last beat before the configuration is touched again
  localparam int SETTLE_CYCLES  = 600;
  localparam int RANDOM_NUMBERS = 170;
  localparam int REPORT_LIMIT   = 200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // ' ' and '~' at indexes 0 and 1, the rest printable and unique
  localparam logic [2*CFG_DATA_W-1:0] HEX_GLYPHS =
    {64'h5F403F2A7D7A615A, 64'h4139302E2C217E20};
  // two digits; the unused bytes hold junk that must be ignored
  localparam logic [2*CFG_DATA_W-1:0] BIN_GLYPHS =
    {64'h2D2D2D2D2B2B2B2B, 64'hFFFFFFFFFFFF7E20};

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_W-1:0]    value     = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [CHAR_W-1:0]     char_code;
  logic                         last_char;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index = '0;
  logic        [CFG_DATA_W-1:0] cfg_data  = '0;

  signed_int_radix_printer_unit dut (.*);

  // shadow of the configuration registers
  logic [RADIX_W-1:0]      radix_m = RADIX_RESET;
  logic [2*CFG_DATA_W-1:0] glyphs  = {CHARS_HI_RESET, CHARS_LO_RESET};

  logic [VALUE_W-1:0] numbers_to_send[$];
  char_beat_t         expected_chars[$];
  char_beat_t         want;
  int                 num_queued   = 0;
  int                 num_accepted = 0;
  int                 mismatches   = 0;
  int unsigned        cycle_cnt    = 0;
  int                 burst_left   = 0;
  int                 gap_left     = 0;
  stall_mode_t        stall_mode   = STALL_NONE;
  int                 stall_left   = 0;

  function automatic logic [CHAR_W-1:0] glyph(input int idx);
    return glyphs[idx*CHAR_W +: CHAR_W];
  endfunction

  function automatic bit alphabet_ok();
    if (radix_m < 2 || radix_m > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix_m; i++) begin
      if (glyph(i) == CHAR_PLUS || glyph(i) == CHAR_MINUS) return 1'b0;
      if (glyph(i) < CHAR_LOW || glyph(i) > CHAR_HIGH) return 1'b0;
      for (int j = i + 1; j < radix_m; j++)
        if (glyph(j) == glyph(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [VALUE_W-1:0] num);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[$];
    if (!alphabet_ok()) return;
    // unsigned magnitude, so the most negative value needs no special path
    mag = num[VALUE_W-1] ? -num : num;
    if (num[VALUE_W-1]) expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
    do begin
      digits.push_front(DIGIT_W'(mag % radix_m));
      mag = mag / radix_m;
    end while (mag != 0);
    foreach (digits[i])
      expected_chars.push_back('{code: glyph(digits[i]), last: i == digits.size() - 1});
  endfunction

  function automatic void send(input logic [VALUE_W-1:0] num);
    numbers_to_send.push_back(num);
    num_queued++;
  endfunction

  function automatic logic [VALUE_W-1:0] random_number();
    logic [VALUE_W-1:0] num;
    case ($urandom_range(0, 9))
      0: num = $urandom_range(0, 40);
      1: num = -$urandom_range(1, 40);
      2: begin
        case ($urandom_range(0, 3))
          0: num = 32'h8000_0000;
          1: num = 32'h7FFF_FFFF;
          2: num = 32'h8000_0001;
          default: num = '1;
        endcase
      end
      3, 4: begin
        num = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) num = -num;
      end
      default: num = $urandom;
    endcase
    return num;
  endfunction

  function automatic logic [2*CFG_DATA_W-1:0] random_alphabet(input int size);
    logic [2*CFG_DATA_W-1:0] chars;
    logic [CHAR_W-1:0]       c;
    bit                      taken[256];
    chars = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < size; i++) begin
      do c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
      while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
      taken[c] = 1'b1;
      chars[i*CHAR_W +: CHAR_W] = c;
    end
    return chars;
  endfunction

  // size is at least 2 on entry
  function automatic void spoil_alphabet(inout logic [RADIX_W-1:0] size,
                                         inout logic [2*CFG_DATA_W-1:0] chars);
    int pos;
    int dup;
    pos = $urandom_range(0, size - 1);
    dup = $urandom_range(1, size - 1);
    case ($urandom_range(0, 5))
      0: size = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                     : RADIX_W'($urandom_range(MAX_RADIX + 1,
                                                               (1 << RADIX_W) - 1));
      1: chars[pos*CHAR_W +: CHAR_W] = CHAR_PLUS;
      2: chars[pos*CHAR_W +: CHAR_W] = CHAR_MINUS;
      3: chars[pos*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(0, CHAR_LOW - 1));
      4: chars[pos*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
      default: chars[dup*CHAR_W +: CHAR_W] =
                 chars[$urandom_range(0, dup - 1)*CHAR_W +: CHAR_W];
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RADIX:    radix_m = data[RADIX_W-1:0];
      REG_CHARS_LO: glyphs[CFG_DATA_W-1:0] = data;
      REG_CHARS_HI: glyphs[2*CFG_DATA_W-1:CFG_DATA_W] = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_alphabet(input logic [CFG_DATA_W-1:0] radix_word,
                               input logic [2*CFG_DATA_W-1:0] chars);
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_CHARS_LO, chars[CFG_DATA_W-1:0]);
    write_reg(REG_CHARS_HI, chars[2*CFG_DATA_W-1:CFG_DATA_W]);
  endtask

  task automatic wait_idle();
    while (num_accepted != num_queued || expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial forever #1 clk = ~clk;

  // sender: bursts of random length, random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (numbers_to_send.size() != 0) begin
        in_valid <= 1'b1;
        value    <= numbers_to_send.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= $urandom_range(0, 7) == 0;
      STALL_HEAVY: out_stall <= $urandom_range(0, 1) == 1;
      default:     out_stall <= (cycle_cnt % 16) < 9;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_text(value);
      num_accepted++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $error("char_code: no beat expected, got %h (last_char %b)", char_code, last_char);
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("char_code: expected %h, got %h", want.code, char_code);
        end
        if (last_char !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("last_char: expected %b, got %b", want.last, last_char);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0]      size;
    logic [2*CFG_DATA_W-1:0] chars;
    logic [CFG_DATA_W-1:0]   radix_word;
    logic [CFG_DATA_W-1:0]   bad_radix[4];
    int                      count;
    bit                      broken;

    bad_radix = '{0, 1, MAX_RADIX + 1, (1 << RADIX_W) - 1};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // decimal alphabet out of reset
    send(0);
    send(1);
    send('1);
    send(32'h7FFF_FFFF);
    send(32'h8000_0000);
    send(1_000_000_000);
    wait_idle();

    // binary: the most negative value gives a sign and 32 digits
    load_alphabet(2, BIN_GLYPHS);
    send(32'h8000_0000);
    send('1);
    send(32'h7FFF_FFFF);
    send(0);
    wait_idle();

    // radix 16 with junk in the upper radix bits; spare index must not disturb
    load_alphabet(64'hFFFF_FFFF_FFFF_FFF0, HEX_GLYPHS);
    write_reg(REG_SPARE, {$urandom, $urandom});
    send(32'h8000_0000);
    send(32'hDEAD_BEEF);
    send(0);
    send(15);
    send(-16);
    wait_idle();

    // bad alphabets: each number is dropped silently
    foreach (bad_radix[k]) begin
      load_alphabet(bad_radix[k], HEX_GLYPHS);
      send($urandom);
      wait_idle();
    end
    for (int k = 0; k < 5; k++) begin
      chars = HEX_GLYPHS;
      case (k)
        0: chars[5*CHAR_W +: CHAR_W] = CHAR_PLUS;
        1: chars[9*CHAR_W +: CHAR_W] = CHAR_MINUS;
        2: chars[15*CHAR_W +: CHAR_W] = chars[0 +: CHAR_W];
        3: chars[3*CHAR_W +: CHAR_W] = CHAR_W'(CHAR_LOW - 1);
        default: chars[12*CHAR_W +: CHAR_W] = CHAR_W'(CHAR_HIGH + 1);
      endcase
      load_alphabet(MAX_RADIX, chars);
      send($urandom);
      wait_idle();
    end

    while (num_queued < RANDOM_NUMBERS) begin
      case ($urandom_range(0, 5))
        0: size = 2;
        1: size = RADIX_W'(MAX_RADIX);
        default: size = RADIX_W'($urandom_range(2, MAX_RADIX));
      endcase
      chars  = random_alphabet(size);
      broken = $urandom_range(0, 5) == 0;
      if (broken) spoil_alphabet(size, chars);
      radix_word = {$urandom, $urandom};
      radix_word[RADIX_W-1:0] = size;
      load_alphabet(radix_word, chars);
      count = $urandom_range(4, 30);
      repeat (count) send(random_number());
      wait_idle();
    end

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
design/sirp_pkg.sv
design/sirp_ram.sv
design/sirp_front.sv
design/sirp_queue.sv
design/sirp_back.sv
design/signed_int_radix_printer_unit.sv
verif/tb_signed_int_radix_printer_unit.sv
